/* rtl/core/pcs_pkg.sv */
// Shared types and constants for the pixel color to symbol quantizer.
`default_nettype none
package pcs_pkg;

  localparam int unsigned COLOR_W = 24;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned SYM_W   = 6;
  localparam int unsigned SQ_W    = 16;
  localparam int unsigned DIST_W  = 18;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  // Larger than any sum of three squared 8-bit differences.
  localparam logic [DIST_W-1:0] DIST_INIT = '1;

  localparam logic [CHAN_W-1:0] RESET_BLUE_MIN  = 8'd200;
  localparam logic [CHAN_W-1:0] RESET_OTHER_MAX = 8'd50;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [1:0] REG_EXTENDED  = 2'd0;
  localparam logic [1:0] REG_BLUE_MIN  = 2'd1;
  localparam logic [1:0] REG_OTHER_MAX = 2'd2;

  typedef struct packed {
    logic              extended_mode;
    logic [CHAN_W-1:0] blue_min;
    logic [CHAN_W-1:0] other_max;
  } cfg_t;

  // Word handed from cell to cell along the palette chain.
  typedef struct packed {
    logic               vld;
    logic               load;
    logic [IDX_W-1:0]   idx;
    logic [COLOR_W-1:0] color;
    logic               fixed;
    logic [SYM_W-1:0]   fixed_sym;
    logic [SYM_W-1:0]   best_idx;
    logic [DIST_W-1:0]  best_dist;
  } word_t;

endpackage
`default_nettype wire

/* rtl/core/pcs_if.sv */
// Input and output channel interfaces of the quantizer.
`default_nettype none
interface pcs_in_if;
  import pcs_pkg::*;
  logic               valid;
  logic               ready;
  logic               func;
  logic [COLOR_W-1:0] pixel_color;
  logic [IDX_W-1:0]   entry_index;
  logic [COLOR_W-1:0] entry_color;
  modport source(output valid, func, pixel_color, entry_index, entry_color, input ready);
  modport sink(input valid, func, pixel_color, entry_index, entry_color, output ready);
endinterface

interface pcs_out_if;
  import pcs_pkg::*;
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  modport source(output valid, symbol, input ready);
  modport sink(input valid, symbol, output ready);
endinterface
`default_nettype wire

/* rtl/core/pcs_cfg.sv */
// APB-style configuration registers of the quantizer.
`default_nettype none
module pcs_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [pcs_pkg::ADDR_W-1:0] paddr,
  input  wire logic [pcs_pkg::DATA_W-1:0] pwdata,
  output logic      [pcs_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output pcs_pkg::cfg_t                   cfg
);
  import pcs_pkg::*;

  logic       wr;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr      = psel & penable & pwrite & pready;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.extended_mode <= 1'b0;
      cfg.blue_min      <= RESET_BLUE_MIN;
      cfg.other_max     <= RESET_OTHER_MAX;
    end else if (wr) begin
      unique case (reg_sel)
        REG_EXTENDED:  cfg.extended_mode <= pwdata[0];
        REG_BLUE_MIN:  cfg.blue_min      <= pwdata[CHAN_W-1:0];
        REG_OTHER_MAX: cfg.other_max     <= pwdata[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_EXTENDED:  prdata = {{(DATA_W-1){1'b0}}, cfg.extended_mode};
      REG_BLUE_MIN:  prdata = {{(DATA_W-CHAN_W){1'b0}}, cfg.blue_min};
      REG_OTHER_MAX: prdata = {{(DATA_W-CHAN_W){1'b0}}, cfg.other_max};
      default:       prdata = '0;
    endcase
  end

  a_blue_min_write: assert property (@(posedge clk) disable iff (rst)
    wr && reg_sel == REG_BLUE_MIN |=> cfg.blue_min == $past(pwdata[CHAN_W-1:0]))
    else $error("blue_min not updated by write");

endmodule
`default_nettype wire

/* rtl/core/pcs_front.sv */
// Entry stage: decodes an input word into a chain word and settles the fixed symbols.
`default_nettype none
module pcs_front (
  input  wire logic                        valid,
  input  wire logic                        func,
  input  wire logic [pcs_pkg::COLOR_W-1:0] pixel_color,
  input  wire logic [pcs_pkg::IDX_W-1:0]   entry_index,
  input  wire logic [pcs_pkg::COLOR_W-1:0] entry_color,
  input  wire pcs_pkg::cfg_t               cfg,
  output pcs_pkg::word_t                   wo
);
  import pcs_pkg::*;

  // Rounds a channel to 0..3 in steps of 85: (v + 42) / 85, capped at 3.
  function automatic logic [1:0] quant(input logic [CHAN_W-1:0] v);
    logic [1:0] q;
    if (v >= 8'd213) q = 2'd3;
    else if (v >= 8'd128) q = 2'd2;
    else if (v >= 8'd43) q = 2'd1;
    else q = 2'd0;
    return q;
  endfunction

  logic [CHAN_W-1:0] b, g, r;
  logic              forced;

  assign b = pixel_color[7:0];
  assign g = pixel_color[15:8];
  assign r = pixel_color[23:16];
  assign forced = (b > cfg.blue_min) && (g < cfg.other_max) && (r < cfg.other_max);

  always_comb begin
    wo.vld       = valid;
    wo.load      = func;
    wo.idx       = entry_index;
    wo.color     = func ? entry_color : pixel_color;
    wo.fixed     = cfg.extended_mode | forced;
    wo.fixed_sym = cfg.extended_mode ? {quant(b), quant(g), quant(r)} : '0;
    wo.best_idx  = '0;
    wo.best_dist = DIST_INIT;
  end

endmodule
`default_nettype wire

/* rtl/core/pcs_cell.sv */
// One palette cell: holds an entry, scores a passing pixel against it, keeps the best.
`default_nettype none
module pcs_cell #(
  parameter int unsigned INDEX = 0
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           adv,
  input  wire pcs_pkg::word_t wi,
  output pcs_pkg::word_t      wo
);
  import pcs_pkg::*;

  localparam logic [6:0]       INDEX_CMP = 7'(INDEX);
  localparam logic [SYM_W-1:0] INDEX_SYM = SYM_W'(INDEX);

  logic [COLOR_W-1:0] entry;
  word_t              sa;
  logic [SQ_W-1:0]    sq_b, sq_g, sq_r;

  logic signed [8:0]  db, dg, dr;
  logic signed [17:0] pb, pg, pr;
  logic [DIST_W-1:0]  dist_sum;
  logic               hit;

  assign db = $signed({1'b0, wi.color[7:0]})   - $signed({1'b0, entry[7:0]});
  assign dg = $signed({1'b0, wi.color[15:8]})  - $signed({1'b0, entry[15:8]});
  assign dr = $signed({1'b0, wi.color[23:16]}) - $signed({1'b0, entry[23:16]});
  assign pb = db * db;
  assign pg = dg * dg;
  assign pr = dr * dr;

  assign hit = wi.vld && wi.load && ({3'b000, wi.idx} == INDEX_CMP);

  // A load word writes the entry as it passes, so earlier pixels keep the old color.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (adv && hit) begin
      entry <= wi.color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sa.vld <= 1'b0;
    end else if (adv) begin
      sa   <= wi;
      sq_b <= pb[SQ_W-1:0];
      sq_g <= pg[SQ_W-1:0];
      sq_r <= pr[SQ_W-1:0];
    end
  end

  assign dist_sum = DIST_W'(sq_b) + DIST_W'(sq_g) + DIST_W'(sq_r);

  // Strict compare keeps the lowest index on a tie.
  always_ff @(posedge clk) begin
    if (rst) begin
      wo.vld <= 1'b0;
    end else if (adv) begin
      wo <= sa;
      if (dist_sum < sa.best_dist) begin
        wo.best_dist <= dist_sum;
        wo.best_idx  <= INDEX_SYM;
      end
    end
  end

  a_entry_write: assert property (@(posedge clk) disable iff (rst)
    adv && hit |=> entry == $past(wi.color))
    else $error("palette entry not written by load word");

  a_best_monotonic: assert property (@(posedge clk) disable iff (rst)
    adv && sa.vld |=> wo.best_dist <= $past(sa.best_dist))
    else $error("best distance grew across a cell");

endmodule
`default_nettype wire

/* rtl/core/pixel_color_to_symbol_top.sv */
// Pixel color to symbol quantizer: palette cell chain with APB configuration.
// Each accepted word passes two registered stages per cell (sa, then wo) on its way to its symbol.
// Throughput: one word per cycle; the chain stalls as a whole only while a symbol waits.
// Load words travel the chain like pixels and write their entry in the matching cell.
// Reset (synchronous, rst high) clears the palette, restores register defaults and
// empties the chain.
`default_nettype none
module pixel_color_to_symbol_top #(
  parameter int unsigned PALETTE_SIZE = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  pcs_in_if.sink                          pix_in,
  pcs_out_if.source                       sym_out,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [pcs_pkg::ADDR_W-1:0] paddr,
  input  wire logic [pcs_pkg::DATA_W-1:0] pwdata,
  output logic      [pcs_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);
  import pcs_pkg::*;

  cfg_t  cfg;
  word_t chain [PALETTE_SIZE+1];
  word_t last;
  logic  adv;

  pcs_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  pcs_front u_front (
    .valid       (pix_in.valid),
    .func        (pix_in.func),
    .pixel_color (pix_in.pixel_color),
    .entry_index (pix_in.entry_index),
    .entry_color (pix_in.entry_color),
    .cfg         (cfg),
    .wo          (chain[0])
  );

  for (genvar i = 0; i < PALETTE_SIZE; i++) begin : g_cell
    pcs_cell #(.INDEX(i)) u_cell (
      .clk, .rst, .adv,
      .wi (chain[i]),
      .wo (chain[i+1])
    );
  end

  // The last cell's output stage is the output register.
  assign last           = chain[PALETTE_SIZE];
  assign sym_out.valid  = last.vld & ~last.load;
  assign sym_out.symbol = last.fixed ? last.fixed_sym : last.best_idx;
  assign adv            = ~sym_out.valid | sym_out.ready;
  assign pix_in.ready   = adv;

  a_stall_only_on_result: assert property (@(posedge clk) disable iff (rst)
    !pix_in.ready |-> sym_out.valid && !sym_out.ready)
    else $error("input stalled without a waiting symbol");

endmodule
`default_nettype wire

/* tb/tb_pixel_color_to_symbol_top.sv */
// Self-checking testbench for the pixel color to symbol quantizer.
module tb_pixel_color_to_symbol_top;
  import pcs_pkg::*;

  localparam int unsigned PALETTE_SIZE = 16;
  localparam int unsigned QUANT_STEP   = 85;
  localparam int unsigned DRAIN_CYCLES = 2 * PALETTE_SIZE + 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned MAX_PRINTED  = 50;
  localparam logic FUNC_CLASSIFY = 1'b0;
  localparam logic FUNC_LOAD     = 1'b1;

  typedef struct {
    logic               func;
    logic [COLOR_W-1:0] pixel;
    logic [IDX_W-1:0]   idx;
    logic [COLOR_W-1:0] color;
  } stim_word_t;

  typedef struct {
    logic [SYM_W-1:0]   symbol;
    logic [COLOR_W-1:0] pixel;
  } symbol_expect_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  pcs_in_if  pix_if ();
  pcs_out_if sym_if ();

  pixel_color_to_symbol_top #(.PALETTE_SIZE(PALETTE_SIZE)) dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_if),
    .sym_out (sym_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the block's palette and registers.
  logic [COLOR_W-1:0] palette_model [PALETTE_SIZE];
  logic               ext_mode_cfg;
  logic [CHAN_W-1:0]  blue_min_cfg;
  logic [CHAN_W-1:0]  other_max_cfg;

  stim_word_t     pending_words [$];
  symbol_expect_t expected_symbols [$];
  stim_word_t     next_word;
  symbol_expect_t oldest_symbol;
  symbol_expect_t fresh_symbol;

  int unsigned mismatch_count = 0;
  int unsigned accepted_items;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned seg_left;
  int unsigned stall_pct;
  int unsigned hold_left;
  int unsigned holds_started;
  int unsigned cycle_count = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED)
      $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic int quant_level(input logic [CHAN_W-1:0] v);
    int q;
    q = (int'(v) + int'(QUANT_STEP / 2)) / int'(QUANT_STEP);
    return (q > 3) ? 3 : q;
  endfunction

  function automatic logic [SYM_W-1:0] predict_symbol(input logic [COLOR_W-1:0] pix);
    int b, g, r, db, dg, dr, sq_sum, best_dist;
    logic [SYM_W-1:0] best;
    b = int'(pix[7:0]);
    g = int'(pix[15:8]);
    r = int'(pix[23:16]);
    if (ext_mode_cfg)
      return SYM_W'(quant_level(pix[7:0]) * 16 + quant_level(pix[15:8]) * 4
                    + quant_level(pix[23:16]));
    // Strongly blue pixels are forced to symbol zero.
    if (b > int'(blue_min_cfg) && g < int'(other_max_cfg) && r < int'(other_max_cfg))
      return '0;
    best = '0;
    best_dist = 2147483647;
    for (int i = 0; i < PALETTE_SIZE; i++) begin
      db = b - int'(palette_model[i][7:0]);
      dg = g - int'(palette_model[i][15:8]);
      dr = r - int'(palette_model[i][23:16]);
      sq_sum = db * db + dg * dg + dr * dr;
      // Strict compare keeps the lowest index on a tie.
      if (sq_sum < best_dist) begin
        best_dist = sq_sum;
        best = SYM_W'(i);
      end
    end
    return best;
  endfunction

  function automatic logic [COLOR_W-1:0] rgb(input int r, input int g, input int b);
    return {r[7:0], g[7:0], b[7:0]};
  endfunction

  function automatic logic [CHAN_W-1:0] jitter(input logic [CHAN_W-1:0] v);
    int t;
    t = int'(v) + int'($urandom_range(6)) - 3;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return t[7:0];
  endfunction

  function automatic logic [CHAN_W-1:0] boundary_level();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd42;
      3: return 8'd43;
      4: return 8'd127;
      5: return 8'd128;
      6: return 8'd212;
      7: return 8'd213;
      8: return 8'd1;
      default: return 8'd254;
    endcase
  endfunction

  function automatic stim_word_t random_word();
    stim_word_t w;
    int unsigned pick;
    logic [COLOR_W-1:0] near;
    w.func  = FUNC_CLASSIFY;
    w.pixel = COLOR_W'($urandom);
    w.idx   = IDX_W'($urandom);
    w.color = COLOR_W'($urandom);
    pick = $urandom_range(99);
    near = palette_model[IDX_W'($urandom_range(PALETTE_SIZE - 1))];
    if (pick < 15) begin
      w.func = FUNC_LOAD;
      // Copying an existing entry sets up equal distances.
      if (pick < 4) w.color = near;
    end else if (pick < 35) begin
      w.pixel = {boundary_level(), boundary_level(), boundary_level()};
    end else if (pick < 60) begin
      w.pixel = {jitter(near[23:16]), jitter(near[15:8]), jitter(near[7:0])};
    end else if (pick < 75) begin
      w.pixel = {jitter(other_max_cfg), jitter(other_max_cfg), jitter(blue_min_cfg)};
    end
    return w;
  endfunction

  task automatic queue_classify(input logic [COLOR_W-1:0] pix);
    stim_word_t w;
    w.func  = FUNC_CLASSIFY;
    w.pixel = pix;
    w.idx   = IDX_W'($urandom);
    w.color = COLOR_W'($urandom);
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic queue_load(input int unsigned slot, input logic [COLOR_W-1:0] color);
    stim_word_t w;
    w.func  = FUNC_LOAD;
    w.pixel = COLOR_W'($urandom);
    w.idx   = slot[IDX_W-1:0];
    w.color = color;
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic run_random(input int unsigned count);
    @(negedge clk);
    repeat (count) pending_words.insert(pending_words.size(), random_word());
  endtask

  // Returns once every word is accepted, every symbol is back and the chain has drained.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_words.size() != 0 || pix_if.valid || expected_symbols.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] readback;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (index)
      REG_EXTENDED:  ext_mode_cfg  = value[0];
      REG_BLUE_MIN:  blue_min_cfg  = value[7:0];
      REG_OTHER_MAX: other_max_cfg = value[7:0];
      default: ;
    endcase
    @(posedge clk);
    psel   <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== value)
      report_mismatch($sformatf("register %0d reads 0x%0h, wrote 0x%0h", index, readback, value));
  endtask

  task automatic apply_settings(input logic mode, input int unsigned bmin, input int unsigned omax);
    wait_idle();
    write_reg(REG_EXTENDED, DATA_W'(mode));
    write_reg(REG_BLUE_MIN, DATA_W'(bmin));
    write_reg(REG_OTHER_MAX, DATA_W'(omax));
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      pix_if.valid   <= 1'b0;
      accepted_items <= 0;
      burst_left     <= $urandom_range(40, 1);
      gap_left       <= 0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        accepted_items <= accepted_items + 1;
        if (pix_if.func == FUNC_LOAD) begin
          palette_model[pix_if.entry_index] = pix_if.entry_color;
        end else begin
          fresh_symbol.symbol = predict_symbol(pix_if.pixel_color);
          fresh_symbol.pixel  = pix_if.pixel_color;
          expected_symbols.insert(expected_symbols.size(), fresh_symbol);
        end
      end
      if (!pix_if.valid || pix_if.ready) begin
        if (gap_left != 0 || pending_words.size() == 0) begin
          pix_if.valid <= 1'b0;
          if (gap_left != 0) gap_left <= gap_left - 1;
        end else begin
          next_word = pending_words.pop_front();
          pix_if.valid       <= 1'b1;
          pix_if.func        <= next_word.func;
          pix_if.pixel_color <= next_word.pixel;
          pix_if.entry_index <= next_word.idx;
          pix_if.entry_color <= next_word.color;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(40, 1);
            gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Two long output hold-offs while the sender keeps offering words.
  always @(posedge clk) begin
    if (rst) begin
      hold_left     <= 0;
      holds_started <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_started < 2 && accepted_items >= 250 + 500 * holds_started) begin
      hold_left     <= HOLD_CYCLES;
      holds_started <= holds_started + 1;
    end
  end

  // Receiver: stall rate changes from one segment to the next; checks each symbol.
  always @(posedge clk) begin
    if (rst) begin
      sym_if.ready <= 1'b0;
      seg_left     <= 0;
      stall_pct    <= 0;
    end else begin
      if (sym_if.valid && sym_if.ready) begin
        if (expected_symbols.size() == 0) begin
          report_mismatch($sformatf("symbol %0d with no pixel outstanding", sym_if.symbol));
        end else begin
          oldest_symbol = expected_symbols.pop_front();
          if (sym_if.symbol !== oldest_symbol.symbol)
            report_mismatch($sformatf("pixel 0x%06h: symbol %0d, expected %0d",
                                      oldest_symbol.pixel, sym_if.symbol, oldest_symbol.symbol));
        end
      end
      if (seg_left == 0) begin
        seg_left  <= $urandom_range(200, 20);
        stall_pct <= 30 * $urandom_range(3);
      end else begin
        seg_left <= seg_left - 1;
      end
      sym_if.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pix_if.valid = 1'b0;
    pix_if.func = FUNC_CLASSIFY;
    pix_if.pixel_color = '0;
    pix_if.entry_index = '0;
    pix_if.entry_color = '0;
    sym_if.ready = 1'b0;
    for (int i = 0; i < PALETTE_SIZE; i++) palette_model[i] = '0;
    ext_mode_cfg  = 1'b0;
    blue_min_cfg  = RESET_BLUE_MIN;
    other_max_cfg = RESET_OTHER_MAX;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset palette: every entry ties, so index zero wins.
    queue_classify(rgb(0, 0, 0));
    queue_classify(rgb(255, 255, 255));
    queue_classify(rgb(0, 0, 255));
    queue_load(0, rgb(255, 255, 255));
    queue_load(1, rgb(0, 0, 0));
    queue_load(2, rgb(255, 0, 0));
    queue_load(3, rgb(0, 255, 0));
    queue_load(4, rgb(0, 0, 255));
    queue_load(5, rgb(128, 128, 128));
    queue_load(6, rgb(0, 0, 0));
    queue_load(15, rgb(1, 2, 3));
    queue_classify(rgb(0, 0, 0));
    queue_classify(rgb(255, 255, 255));
    queue_classify(rgb(0, 0, 255));
    queue_classify(rgb(0, 0, 200));
    queue_classify(rgb(49, 0, 255));
    queue_classify(rgb(50, 0, 255));
    queue_classify(rgb(0, 50, 255));
    queue_classify(rgb(1, 2, 3));

    // Extended mode, with channels on both sides of each rounding step.
    apply_settings(1'b1, 200, 50);
    @(negedge clk);
    queue_classify(rgb(42, 43, 127));
    queue_classify(rgb(128, 212, 213));
    queue_classify(rgb(255, 0, 42));
    queue_classify(rgb(43, 127, 128));
    run_random(150);

    apply_settings(1'b0, 0, 255);
    run_random(200);
    apply_settings(1'b0, 255, 0);
    run_random(200);
    apply_settings(1'b1, 0, 0);
    run_random(150);
    apply_settings(1'b0, $urandom_range(255), $urandom_range(255));
    run_random(250);
    apply_settings(1'b0, 200, 50);
    run_random(200);

    wait_idle();
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
